FILE: design/rlfe_pkg.sv
// Package for the RGB linear fade engine: command and register codes,
// widths, and the constant-reciprocal divide used by the fade datapath.
// No dependencies.
`default_nettype none

package rlfe_pkg;

    // number of fade steps from start colour to goal colour
    localparam int FADE_STEPS = 32;
    localparam int FADE_DIV   = FADE_STEPS - 1;

    localparam int STEP_W = $clog2(FADE_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FADE_STEPS);

    // accumulated |goal - start| * step, at most 255 * FADE_STEPS
    localparam int M_W = $clog2(255 * FADE_STEPS + 1);

    // m / FADE_DIV == (m * RECIP) >> SHIFT exactly for every m below 2**M_W
    localparam int SHIFT   = M_W + $clog2(FADE_STEPS);
    localparam int RECIP_W = SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**SHIFT + FADE_DIV - 1) / FADE_DIV);

    localparam int CFG_W = 16;
    localparam int CIDX_W = 2;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_PULSE = 2'd2;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_UPDATE_PERIOD = 2'd0;
    localparam logic [CIDX_W-1:0] REG_PULSE_PERIOD  = 2'd1;

    localparam logic [CFG_W-1:0] UPDATE_PERIOD_RST = 16'd20;
    localparam logic [CFG_W-1:0] PULSE_PERIOD_RST  = 16'd1000;

    typedef logic [2:0][7:0]     rgb_t;
    typedef logic [2:0][M_W-1:0] acc_t;

    function automatic logic [7:0] div_steps(input logic [M_W-1:0] m);
        logic [M_W+RECIP_W-1:0] p;
        p = {{RECIP_W{1'b0}}, m} * {{M_W{1'b0}}, RECIP};
        return p[SHIFT +: 8];
    endfunction

endpackage

`default_nettype wire

FILE: design/rgb_linear_fade_engine.sv
// RGB linear fade engine top level: timers, fade datapath, output skid.
// Depends on rlfe_pkg.
`default_nettype none
//
// channel  signals                                       direction
// -------  --------------------------------------------  ---------
// input    in_valid in_ready cmd target_red/green/blue    in
// output   out_valid out_ready led_red/green/blue         out
// config   cfg_write cfg_index cfg_data                   in
//
// One transaction per cycle on the input; the fade value is one constant-reciprocal
// multiply per channel on a running product, between the state registers and the
// result register. A two-entry output (result register plus skid) lets the input
// keep taking transactions while a result waits. in_ready drops only when both
// entries are full. Reset clears all state but the output data; no clearing pass.

module rgb_linear_fade_engine (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   cmd,
    input  wire logic [7:0]                   target_red,
    input  wire logic [7:0]                   target_green,
    input  wire logic [7:0]                   target_blue,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [7:0]                        led_red,
    output logic [7:0]                        led_green,
    output logic [7:0]                        led_blue,
    input  wire logic                         cfg_write,
    input  wire logic [rlfe_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [rlfe_pkg::CFG_W-1:0]   cfg_data
);

    logic [rlfe_pkg::CFG_W-1:0] update_period_reg;
    logic [rlfe_pkg::CFG_W-1:0] pulse_period_reg;

    rlfe_pkg::rgb_t start_reg, start_next;
    rlfe_pkg::rgb_t goal_reg, goal_next;
    rlfe_pkg::rgb_t disp_reg, disp_next;
    rlfe_pkg::rgb_t absdiff_reg, absdiff_next;
    logic [2:0]     neg_reg, neg_next;
    rlfe_pkg::acc_t acc_reg, acc_next;
    logic [rlfe_pkg::STEP_W-1:0] step_reg, step_next;
    logic [15:0]    upd_elapsed_reg, upd_elapsed_next;
    logic [15:0]    pls_elapsed_reg, pls_elapsed_next;
    logic           pulse_active_reg, pulse_active_next;

    rlfe_pkg::rgb_t out_data_reg, out_data_next;
    rlfe_pkg::rgb_t skid_data_reg, skid_data_next;
    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;

    rlfe_pkg::rgb_t shown;
    rlfe_pkg::rgb_t latch_goal;
    logic           do_latch;
    logic           produce;
    logic           in_fire;
    logic           out_fire;
    logic [15:0]    upd_inc;
    logic [15:0]    pls_inc;
    logic [7:0]     q;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_fire  = out_valid_reg && out_ready;
    assign led_red   = out_data_reg[0];
    assign led_green = out_data_reg[1];
    assign led_blue  = out_data_reg[2];

    assign upd_inc = (upd_elapsed_reg == 16'hFFFF) ? upd_elapsed_reg : upd_elapsed_reg + 16'd1;
    assign pls_inc = (pls_elapsed_reg == 16'hFFFF) ? pls_elapsed_reg : pls_elapsed_reg + 16'd1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            update_period_reg <= rlfe_pkg::UPDATE_PERIOD_RST;
            pulse_period_reg  <= rlfe_pkg::PULSE_PERIOD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rlfe_pkg::REG_UPDATE_PERIOD: update_period_reg <= cfg_data;
                rlfe_pkg::REG_PULSE_PERIOD:  pulse_period_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        start_next        = start_reg;
        goal_next         = goal_reg;
        disp_next         = disp_reg;
        absdiff_next      = absdiff_reg;
        neg_next          = neg_reg;
        acc_next          = acc_reg;
        step_next         = step_reg;
        upd_elapsed_next  = upd_elapsed_reg;
        pls_elapsed_next  = pls_elapsed_reg;
        pulse_active_next = pulse_active_reg;
        do_latch          = 1'b0;
        latch_goal        = '0;
        produce           = 1'b0;
        q                 = '0;

        // colour for the current step: start +/- (|diff| * step) / (FADE_STEPS - 1), goal at the last step
        for (int i = 0; i < 3; i++)
        begin
            q = rlfe_pkg::div_steps(acc_reg[i]);
            if (step_reg >= rlfe_pkg::STEP_LAST)
                shown[i] = goal_reg[i];
            else if (neg_reg[i])
                shown[i] = start_reg[i] - q;
            else
                shown[i] = start_reg[i] + q;
        end

        if (in_fire)
        begin
            case (cmd)
                rlfe_pkg::CMD_SET:
                begin
                    do_latch   = 1'b1;
                    latch_goal = {target_blue, target_green, target_red};
                end
                rlfe_pkg::CMD_PULSE:
                begin
                    do_latch          = 1'b1;
                    latch_goal        = {target_blue, target_green, target_red};
                    pulse_active_next = 1'b1;
                    pls_elapsed_next  = '0;
                end
                rlfe_pkg::CMD_TICK:
                begin
                    upd_elapsed_next = upd_inc;
                    if (upd_inc >= update_period_reg)
                    begin
                        upd_elapsed_next = '0;
                        produce          = 1'b1;
                        disp_next        = shown;
                        if (step_reg < rlfe_pkg::STEP_LAST)
                        begin
                            step_next = step_reg + 1'b1;
                            for (int i = 0; i < 3; i++)
                                acc_next[i] = acc_reg[i] + rlfe_pkg::M_W'(absdiff_reg[i]);
                        end
                    end
                    pls_elapsed_next = pls_inc;
                    // pulse over: fade back to black from what is on show now
                    if (pulse_active_reg && pls_inc >= pulse_period_reg)
                    begin
                        do_latch          = 1'b1;
                        latch_goal        = '0;
                        pulse_active_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        if (do_latch)
        begin
            goal_next  = latch_goal;
            start_next = disp_next;
            step_next  = '0;
            acc_next   = '0;
            for (int i = 0; i < 3; i++)
            begin
                neg_next[i] = latch_goal[i] < disp_next[i];
                absdiff_next[i] = neg_next[i] ? disp_next[i] - latch_goal[i]
                                              : latch_goal[i] - disp_next[i];
            end
        end
    end

    // result register and skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !out_ready)
        begin
            if (produce)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = disp_next;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = produce;
            if (produce)
                skid_data_next = disp_next;
        end
        else
        begin
            out_valid_next = produce;
            if (produce)
                out_data_next = disp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg        <= '0;
            goal_reg         <= '0;
            disp_reg         <= '0;
            absdiff_reg      <= '0;
            neg_reg          <= '0;
            acc_reg          <= '0;
            step_reg         <= '0;
            upd_elapsed_reg  <= '0;
            pls_elapsed_reg  <= '0;
            pulse_active_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            start_reg        <= start_next;
            goal_reg         <= goal_next;
            disp_reg         <= disp_next;
            absdiff_reg      <= absdiff_next;
            neg_reg          <= neg_next;
            acc_reg          <= acc_next;
            step_reg         <= step_next;
            upd_elapsed_reg  <= upd_elapsed_next;
            pls_elapsed_reg  <= pls_elapsed_next;
            pulse_active_reg <= pulse_active_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // skid holds a result only behind a waiting result register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty result register");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= rlfe_pkg::STEP_LAST)
        else $error("step count beyond last step");

    // running product tracks |diff| * step on every channel
    a_acc_product: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg[0] == rlfe_pkg::M_W'(absdiff_reg[0] * step_reg)) &&
        (acc_reg[1] == rlfe_pkg::M_W'(absdiff_reg[1] * step_reg)) &&
        (acc_reg[2] == rlfe_pkg::M_W'(absdiff_reg[2] * step_reg)))
        else $error("fade accumulator out of step");

    // a stalled result is never overwritten
    a_stall_keeps_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_valid_reg && !out_ready) |=>
            (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid entry lost during stall");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for rgb_linear_fade_engine: directed fade, pulse and
// period cases, then random traffic under random input gaps and output stalls.
// Depends on rlfe_pkg and the rgb_linear_fade_engine RTL.

module testbench;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         DRAIN_LIMIT   = 5000;
    localparam int         PHASE_ITEMS   = 110;
    localparam int         PHASE_COUNT   = 12;

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_ready;
    logic [1:0]                    cmd          = rlfe_pkg::CMD_TICK;
    logic [7:0]                    target_red   = 8'd0;
    logic [7:0]                    target_green = 8'd0;
    logic [7:0]                    target_blue  = 8'd0;
    logic                          out_valid;
    logic                          out_ready    = 1'b0;
    logic [7:0]                    led_red;
    logic [7:0]                    led_green;
    logic [7:0]                    led_blue;
    logic                          cfg_write    = 1'b0;
    logic [rlfe_pkg::CIDX_W-1:0]   cfg_index    = rlfe_pkg::REG_UPDATE_PERIOD;
    logic [rlfe_pkg::CFG_W-1:0]    cfg_data     = '0;

    // fade engine state as the testbench tracks it; index 0 is red
    rlfe_pkg::rgb_t start_color;
    rlfe_pkg::rgb_t goal_color;
    rlfe_pkg::rgb_t shown_color;
    int   fade_step;
    int   update_ticks;
    int   pulse_ticks;
    bit   pulse_pending;
    int   cfg_update_period;
    int   cfg_pulse_period;

    rlfe_pkg::rgb_t led_queue[$];
    int   error_count;
    int   burst_left;
    bit   input_held;

    rgb_linear_fade_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .target_red   (target_red),
        .target_green (target_green),
        .target_blue  (target_blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .led_red      (led_red),
        .led_green    (led_green),
        .led_blue     (led_blue),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // signed fade with truncation toward zero, clamped to a byte
    function automatic logic [7:0] fade_level(input logic [7:0] from, input logic [7:0] to,
                                              input int k);
        int diff;
        int level;
        diff  = int'(to) - int'(from);
        level = int'(from) + (diff * k) / (rlfe_pkg::FADE_STEPS - 1);
        if (level < 0)
            level = 0;
        if (level > 255)
            level = 255;
        return level[7:0];
    endfunction

    function automatic void latch_goal(input rlfe_pkg::rgb_t goal);
        goal_color  = goal;
        start_color = shown_color;
        fade_step   = 0;
    endfunction

    function automatic void apply_command(input logic [1:0] c, input rlfe_pkg::rgb_t target);
        case (c)
            rlfe_pkg::CMD_SET:
                latch_goal(target);
            rlfe_pkg::CMD_PULSE:
            begin
                pulse_pending = 1'b1;
                pulse_ticks   = 0;
                latch_goal(target);
            end
            rlfe_pkg::CMD_TICK:
            begin
                if (update_ticks < 65535)
                    update_ticks++;
                if (update_ticks >= cfg_update_period)
                begin
                    update_ticks = 0;
                    for (int i = 0; i < 3; i++)
                        shown_color[i] = (fade_step >= rlfe_pkg::FADE_STEPS) ? goal_color[i]
                                       : fade_level(start_color[i], goal_color[i], fade_step);
                    if (fade_step < rlfe_pkg::FADE_STEPS)
                        fade_step++;
                    led_queue.push_back(shown_color);
                end
                if (pulse_ticks < 65535)
                    pulse_ticks++;
                if (pulse_pending && pulse_ticks >= cfg_pulse_period)
                begin
                    latch_goal('0);
                    pulse_pending = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    // enter and leave at a falling edge; valid stays up across a burst
    task automatic send_item(input logic [1:0] c, input rlfe_pkg::rgb_t target);
        cmd          <= c;
        target_red   <= target[0];
        target_green <= target[1];
        target_blue  <= target[2];
        in_valid     <= 1'b1;
        input_held    = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_command(c, target);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid  <= 1'b0;
            input_held = 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(8, 30)) @(negedge clk);
            else
                repeat ($urandom_range(1, 4)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // drop valid, wait out every expected result plus the pipeline latency
    task automatic settle();
        int waited;
        waited = 0;
        if (input_held)
        begin
            in_valid  <= 1'b0;
            input_held = 1'b0;
        end
        while (led_queue.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [rlfe_pkg::CIDX_W-1:0] idx,
                                  input logic [rlfe_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == rlfe_pkg::REG_UPDATE_PERIOD)
            cfg_update_period = int'(val);
        else if (idx == rlfe_pkg::REG_PULSE_PERIOD)
            cfg_pulse_period = int'(val);
    endtask

    task automatic set_periods(input int update_len, input int pulse_len);
        settle();
        write_register(rlfe_pkg::REG_UPDATE_PERIOD, rlfe_pkg::CFG_W'(update_len));
        write_register(rlfe_pkg::REG_PULSE_PERIOD, rlfe_pkg::CFG_W'(pulse_len));
    endtask

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic rlfe_pkg::rgb_t random_color();
        return rlfe_pkg::rgb_t'({random_channel(), random_channel(), random_channel()});
    endfunction

    function automatic rlfe_pkg::rgb_t make_color(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
        return rlfe_pkg::rgb_t'({b, g, r});
    endfunction

    task automatic send_ticks(input int n);
        repeat (n) send_item(rlfe_pkg::CMD_TICK, random_color());
    endtask

    // fade up, fade down through a pulse, ignored command, extreme targets
    task automatic test_fade_and_pulse();
        send_item(rlfe_pkg::CMD_SET, make_color(8'd10, 8'd20, 8'd30));
        send_ticks(2);
        set_periods(1, 3);
        send_item(rlfe_pkg::CMD_SET, make_color(8'd255, 8'd0, 8'd128));
        send_ticks(3);
        send_item(rlfe_pkg::CMD_PULSE, make_color(8'd0, 8'd255, 8'd255));
        send_ticks(4);
        send_item(CMD_UNUSED, make_color(8'd255, 8'd255, 8'd255));
        send_ticks(1);
        send_item(rlfe_pkg::CMD_SET, make_color(8'd255, 8'd255, 8'd255));
        send_item(rlfe_pkg::CMD_SET, make_color(8'd0, 8'd0, 8'd0));
        send_ticks(1);
        // set target while a pulse is pending: black still follows
        send_item(rlfe_pkg::CMD_PULSE, make_color(8'd255, 8'd255, 8'd255));
        send_item(rlfe_pkg::CMD_SET, make_color(8'd1, 8'd254, 8'd128));
        send_ticks(4);
    endtask

    // largest periods, then shrink below the elapsed count; zero periods
    task automatic test_period_extremes();
        set_periods(65535, 65535);
        send_item(rlfe_pkg::CMD_PULSE, make_color(8'd200, 8'd100, 8'd50));
        send_ticks(4);
        set_periods(2, 1);
        send_ticks(2);
        set_periods(0, 0);
        send_item(rlfe_pkg::CMD_PULSE, make_color(8'd255, 8'd0, 8'd255));
        send_ticks(2);
    endtask

    task automatic test_random_traffic();
        int   sent;
        int   ticks;
        int   update_len;
        int   pulse_len;
        rlfe_pkg::rgb_t target;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       update_len = 0;
                1:       update_len = 1;
                2, 3:    update_len = $urandom_range(2, 4);
                default: update_len = $urandom_range(5, 12);
            endcase
            case ($urandom_range(0, 5))
                0:       pulse_len = 0;
                1:       pulse_len = 1;
                2:       pulse_len = 65535;
                default: pulse_len = $urandom_range(2, 80);
            endcase
            set_periods(update_len, pulse_len);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                target = random_color();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        send_item(rlfe_pkg::CMD_SET, target);
                        ticks = $urandom_range(1, 40);
                    end
                    4, 5, 6:
                    begin
                        send_item(rlfe_pkg::CMD_PULSE, target);
                        ticks = $urandom_range(1, 60);
                    end
                    7:
                    begin
                        send_item(CMD_UNUSED, target);
                        ticks = 0;
                    end
                    default:
                    begin
                        send_item(2'($urandom_range(0, 2)), target);
                        ticks = 0;
                    end
                endcase
                // keep each phase at its item budget
                if (ticks > PHASE_ITEMS - sent - 1)
                    ticks = PHASE_ITEMS - sent - 1;
                send_ticks(ticks);
                sent = sent + 1 + ticks;
            end
        end
    endtask

    // receiver stall pattern: stretches of always-ready, coin-flip, mostly
    // ready and mostly stalled
    initial
    begin
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 60);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 7) != 0);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // compare each result transaction with the oldest expected color
    always @(posedge clk)
    begin
        rlfe_pkg::rgb_t expected_color;
        if (rst_n && out_valid && out_ready)
        begin
            if (led_queue.size() == 0)
                report_mismatch($sformatf("unexpected result %0d %0d %0d",
                                          led_red, led_green, led_blue));
            else
            begin
                expected_color = led_queue.pop_front();
                if (led_red !== expected_color[0])
                    report_mismatch($sformatf("led_red got %0d expected %0d",
                                              led_red, expected_color[0]));
                if (led_green !== expected_color[1])
                    report_mismatch($sformatf("led_green got %0d expected %0d",
                                              led_green, expected_color[1]));
                if (led_blue !== expected_color[2])
                    report_mismatch($sformatf("led_blue got %0d expected %0d",
                                              led_blue, expected_color[2]));
            end
        end
    end

    initial
    begin
        start_color       = '0;
        goal_color        = '0;
        shown_color       = '0;
        fade_step         = 0;
        update_ticks      = 0;
        pulse_ticks       = 0;
        pulse_pending     = 1'b0;
        cfg_update_period = int'(rlfe_pkg::UPDATE_PERIOD_RST);
        cfg_pulse_period  = int'(rlfe_pkg::PULSE_PERIOD_RST);
        error_count       = 0;
        burst_left        = 0;
        input_held        = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_fade_and_pulse();
        test_period_extremes();
        test_random_traffic();

        settle();
        if (led_queue.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", led_queue.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
